@@ design/tvrp_pkg.sv @@
`default_nettype none

package tvrp_pkg;

  localparam int unsigned NumLevels = 7;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);
  localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);

  localparam logic [2:0] PhTag    = 3'd0;
  localparam logic [2:0] PhLevel  = 3'd1;
  localparam logic [2:0] PhNum    = 3'd2;
  localparam logic [2:0] PhSlen   = 3'd3;
  localparam logic [2:0] PhSbytes = 3'd4;

  localparam logic [3:0] TagString    = 4'd1;
  localparam logic [3:0] TagNumA      = 4'd2;
  localparam logic [3:0] TagNumB      = 4'd3;
  localparam logic [3:0] TagNumC      = 4'd4;
  localparam logic [3:0] TagLevelStr  = 4'd5;
  localparam logic [3:0] TagLevelNum  = 4'd6;
  localparam logic [3:0] TagLevelFull = 4'd7;
  localparam logic [3:0] TagNumD      = 4'd9;

  localparam logic [1:0] KindScalar = 2'd0;
  localparam logic [1:0] KindStrLen = 2'd1;
  localparam logic [1:0] KindStrByte = 2'd2;
  localparam logic [1:0] KindEnd    = 2'd3;

  localparam logic [2:0] ErrNone       = 3'd0;
  localparam logic [2:0] ErrBadTag     = 3'd1;
  localparam logic [2:0] ErrUnknownTag = 3'd2;
  localparam logic [2:0] ErrBadLevel   = 3'd3;
  localparam logic [2:0] ErrBadNumber  = 3'd4;
  localparam logic [2:0] ErrBadString  = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [3:0]  entry_tag;
    logic [2:0]  field_index;
    logic [63:0] field_value;
    logic [2:0]  error_code;
    logic        record_done;
  } out_word_t;

  typedef struct packed {
    logic [1:0] num;
    out_word_t  first;
    out_word_t  second;
  } evq_write_t;

  function automatic logic [2:0] layout(logic [3:0] tag, logic [2:0] field);
    logic [2:0] ph;
    ph = PhTag;
    unique case (tag) inside
      TagString: ph = (field == 3'd0) ? PhSlen : PhTag;
      TagNumA, TagNumB, TagNumC, TagNumD: ph = (field == 3'd0) ? PhNum : PhTag;
      TagLevelStr: begin
        if (field == 3'd0) ph = PhLevel;
        else if (field == 3'd1) ph = PhSlen;
        else ph = PhTag;
      end
      TagLevelNum: begin
        if (field == 3'd0) ph = PhLevel;
        else if (field == 3'd1) ph = PhNum;
        else ph = PhTag;
      end
      TagLevelFull: begin
        if (field == 3'd0) ph = PhLevel;
        else if (field <= 3'd2) ph = PhNum;
        else if (field <= 3'd4) ph = PhSlen;
        else ph = PhTag;
      end
      default: ph = PhTag;
    endcase
    return ph;
  endfunction

  function automatic logic [2:0] phase_error(logic [2:0] ph);
    logic [2:0] err;
    err = ErrBadString;
    unique case (ph)
      PhTag:   err = ErrBadTag;
      PhLevel: err = ErrBadLevel;
      PhNum:   err = ErrBadNumber;
      default: err = ErrBadString;
    endcase
    return err;
  endfunction

  function automatic logic tag_known(logic [31:0] v);
    return (v >= 32'd1 && v <= 32'd7) || v == 32'd9;
  endfunction

endpackage

`default_nettype wire

@@ design/tvrp_front.sv @@
`default_nettype none

module tvrp_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire tvrp_pkg::in_word_t   item_i,
  output tvrp_pkg::evq_write_t      wr_o
);

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  tag_q, tag_d;
  logic [2:0]  field_q, field_d;
  logic [63:0] acc_q, acc_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] sleft_q, sleft_d;
  logic [2:0]  err_q, err_d;

  logic [7:0]  b;
  logic [6:0]  shamt_w;
  logic [63:0] acc_v;
  logic [63:0] val;
  logic [3:0]  cnt_v;
  logic [3:0]  maxb;
  logic [2:0]  err_f;
  logic        has_data;
  logic        has_end;
  tvrp_pkg::out_word_t ev_data;
  tvrp_pkg::out_word_t ev_end;

  assign b = item_i.data_byte;
  assign shamt_w = {cnt_q, 3'b000} - {3'b000, cnt_q};
  assign acc_v = acc_q | ({57'b0, b[6:0]} << shamt_w);
  assign cnt_v = cnt_q + 4'd1;
  assign maxb = (phase_q == tvrp_pkg::PhNum) ? 4'd10 : 4'd5;
  assign val = (phase_q == tvrp_pkg::PhNum) ? acc_v : {32'b0, acc_v[31:0]};

  always_comb begin
    phase_d  = phase_q;
    tag_d    = tag_q;
    field_d  = field_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    sleft_d  = sleft_q;
    err_d    = err_q;
    err_f    = tvrp_pkg::ErrNone;
    has_data = 1'b0;
    has_end  = 1'b0;
    ev_data  = '0;
    ev_end   = '0;
    ev_data.entry_tag   = tag_q;
    ev_data.field_index = field_q;
    if (accept_i) begin
      if (err_q == tvrp_pkg::ErrNone) begin
        if (phase_q == tvrp_pkg::PhSbytes) begin
          has_data = 1'b1;
          ev_data.event_kind  = tvrp_pkg::KindStrByte;
          ev_data.field_value = {56'b0, b};
          sleft_d = sleft_q - 32'd1;
          if (sleft_q == 32'd1) begin
            field_d = field_q + 3'd1;
            phase_d = tvrp_pkg::layout(tag_q, field_q + 3'd1);
          end
        end else if (b[7]) begin
          acc_d = acc_v;
          cnt_d = cnt_v;
          if (cnt_v >= maxb) begin
            err_d = tvrp_pkg::phase_error(phase_q);
          end
        end else begin
          acc_d = '0;
          cnt_d = '0;
          unique case (phase_q)
            tvrp_pkg::PhTag: begin
              if (tvrp_pkg::tag_known(val[31:0])) begin
                tag_d   = val[3:0];
                field_d = 3'd0;
                phase_d = tvrp_pkg::layout(val[3:0], 3'd0);
              end else begin
                err_d = tvrp_pkg::ErrUnknownTag;
              end
            end
            tvrp_pkg::PhLevel: begin
              if (val[31:0] >= 32'(tvrp_pkg::NumLevels)) begin
                err_d = tvrp_pkg::ErrBadLevel;
              end else begin
                has_data = 1'b1;
                ev_data.event_kind  = tvrp_pkg::KindScalar;
                ev_data.field_value = val;
                field_d = field_q + 3'd1;
                phase_d = tvrp_pkg::layout(tag_q, field_q + 3'd1);
              end
            end
            tvrp_pkg::PhNum: begin
              has_data = 1'b1;
              ev_data.event_kind  = tvrp_pkg::KindScalar;
              ev_data.field_value = val;
              field_d = field_q + 3'd1;
              phase_d = tvrp_pkg::layout(tag_q, field_q + 3'd1);
            end
            default: begin
              has_data = 1'b1;
              ev_data.event_kind  = tvrp_pkg::KindStrLen;
              ev_data.field_value = val;
              if (val[31:0] == 32'd0) begin
                field_d = field_q + 3'd1;
                phase_d = tvrp_pkg::layout(tag_q, field_q + 3'd1);
              end else begin
                sleft_d = val[31:0];
                phase_d = tvrp_pkg::PhSbytes;
              end
            end
          endcase
        end
      end
      if (item_i.final_byte) begin
        err_f = err_d;
        if (err_d == tvrp_pkg::ErrNone && (phase_d != tvrp_pkg::PhTag || cnt_d != 4'd0)) begin
          err_f = tvrp_pkg::phase_error(phase_d);
        end
        has_end = 1'b1;
        ev_end.event_kind  = tvrp_pkg::KindEnd;
        ev_end.error_code  = err_f;
        ev_end.record_done = 1'b1;
        phase_d = tvrp_pkg::PhTag;
        tag_d   = '0;
        field_d = '0;
        acc_d   = '0;
        cnt_d   = '0;
        sleft_d = '0;
        err_d   = tvrp_pkg::ErrNone;
      end
    end
  end

  assign wr_o.num    = {1'b0, has_data} + {1'b0, has_end};
  assign wr_o.first  = has_data ? ev_data : ev_end;
  assign wr_o.second = ev_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tvrp_pkg::PhTag;
      tag_q   <= '0;
      field_q <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
      sleft_q <= '0;
      err_q   <= tvrp_pkg::ErrNone;
    end else begin
      phase_q <= phase_d;
      tag_q   <= tag_d;
      field_q <= field_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      sleft_q <= sleft_d;
      err_q   <= err_d;
    end
  end

endmodule

`default_nettype wire

@@ design/tvrp_evq.sv @@
`default_nettype none

module tvrp_evq (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire tvrp_pkg::evq_write_t  wr_i,
  input  wire logic                  pop_i,
  output logic                       full_o,
  output logic                       empty_o,
  output tvrp_pkg::out_word_t        head_o
);

  tvrp_pkg::out_word_t slot_q [tvrp_pkg::QueueDepth];
  logic [tvrp_pkg::QueuePtrW-1:0] head_q, head_d;
  logic [tvrp_pkg::QueueCntW-1:0] count_q, count_d;
  logic [tvrp_pkg::QueuePtrW-1:0] tail;
  logic [tvrp_pkg::QueuePtrW-1:0] tail_next;
  logic                           do_pop;

  assign empty_o   = (count_q == '0);
  assign full_o    = (count_q > tvrp_pkg::QueueCntW'(tvrp_pkg::QueueDepth - 2));
  assign head_o    = slot_q[head_q];
  assign do_pop    = pop_i && !empty_o;
  assign tail      = head_q + count_q[tvrp_pkg::QueuePtrW-1:0];
  assign tail_next = tail + {{(tvrp_pkg::QueuePtrW-1){1'b0}}, 1'b1};

  always_comb begin
    head_d  = head_q;
    count_d = count_q + tvrp_pkg::QueueCntW'(wr_i.num);
    if (do_pop) begin
      head_d  = head_q + {{(tvrp_pkg::QueuePtrW-1){1'b0}}, 1'b1};
      count_d = count_d - {{(tvrp_pkg::QueueCntW-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.num != 2'd0) begin
      slot_q[tail] <= wr_i.first;
    end
    if (wr_i.num == 2'd2) begin
      slot_q[tail_next] <= wr_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

@@ design/tagged_varint_record_parser_unit.sv @@
// Channel   Direction  Handshake          Word
// input     in         push / full        item_i   (data_byte, final_byte)
// result    out        pop / empty        result_o (event kind, tag, field, value, status)
//
// A byte is decoded in the cycle it is offered and its words enter the queue at the
// accepting edge, so the first of them can be popped from the next cycle on. A byte yields up
// to two result words, and the four-entry result queue accepts a byte whenever it has
// room for two, so one byte per cycle is sustained while the bytes yield no more words
// than the consumer pops. Reset is asynchronous and clears the parser state and the
// queue. A stalled consumer fills the queue, which then raises full and stalls the input.

`default_nettype none

module tagged_varint_record_parser_unit (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push,
  output logic                      full,
  input  wire tvrp_pkg::in_word_t   item_i,
  output logic                      empty,
  input  wire logic                 pop,
  output tvrp_pkg::out_word_t       result_o
);

  tvrp_pkg::evq_write_t wr;
  logic                 accept;

  assign accept = push && !full;

  tvrp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item_i),
    .wr_o     (wr)
  );

  tvrp_evq u_evq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (result_o)
  );

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import tvrp_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  in_word_t  item_i = '0;
  logic      full;
  logic      empty;
  out_word_t result_o;

  tagged_varint_record_parser_unit u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .item_i   (item_i),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

  in_word_t    byte_queue[$];
  out_word_t   expected_words[$];
  logic [7:0]  rec[$];

  logic [2:0]  dec_phase;
  logic [3:0]  dec_tag;
  logic [2:0]  dec_field;
  logic [63:0] dec_acc;
  logic [3:0]  dec_count;
  logic [31:0] dec_left;
  logic [2:0]  dec_err;

  int unsigned bytes_sent;
  int unsigned words_checked;
  int unsigned records_queued;
  int unsigned records_seen;
  int unsigned error_records;
  int unsigned fail_count;
  logic        hold_off = 1'b0;
  logic [3:0]  known_tags[8];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [2:0] entry_phase(logic [3:0] tag, logic [2:0] field);
    logic [2:0] ph;
    ph = PhTag;
    case (tag)
      TagString: if (field == 3'd0) ph = PhSlen;
      TagNumA, TagNumB, TagNumC, TagNumD: if (field == 3'd0) ph = PhNum;
      TagLevelStr: begin
        if (field == 3'd0) ph = PhLevel;
        else if (field == 3'd1) ph = PhSlen;
      end
      TagLevelNum: begin
        if (field == 3'd0) ph = PhLevel;
        else if (field == 3'd1) ph = PhNum;
      end
      TagLevelFull: begin
        if (field == 3'd0) ph = PhLevel;
        else if (field <= 3'd2) ph = PhNum;
        else if (field <= 3'd4) ph = PhSlen;
      end
      default: ph = PhTag;
    endcase
    return ph;
  endfunction

  function automatic logic [2:0] pending_error(logic [2:0] ph);
    if (ph == PhTag) return ErrBadTag;
    if (ph == PhLevel) return ErrBadLevel;
    if (ph == PhNum) return ErrBadNumber;
    return ErrBadString;
  endfunction

  task automatic clear_decoder();
    dec_phase = PhTag;
    dec_tag = '0;
    dec_field = '0;
    dec_acc = '0;
    dec_count = '0;
    dec_left = '0;
    dec_err = ErrNone;
  endtask

  task automatic add_word(input logic [1:0] kind, input logic [63:0] value);
    out_word_t w;
    w = '0;
    w.event_kind = kind;
    w.entry_tag = dec_tag;
    w.field_index = dec_field;
    w.field_value = value;
    expected_words.push_back(w);
  endtask

  task automatic next_field();
    dec_field = dec_field + 3'd1;
    dec_phase = entry_phase(dec_tag, dec_field);
  endtask

  task automatic decode_byte(input in_word_t w);
    logic [7:0]  b;
    logic [63:0] v;
    int          lim;
    out_word_t   done_word;
    b = w.data_byte;
    if (dec_err == ErrNone) begin
      if (dec_phase == PhSbytes) begin
        add_word(KindStrByte, {56'd0, b});
        dec_left = dec_left - 32'd1;
        if (dec_left == 32'd0) next_field();
      end else begin
        lim = (dec_phase == PhNum) ? 10 : 5;
        if (dec_count < 4'd10) dec_acc = dec_acc | ({57'd0, b[6:0]} << (7 * int'(dec_count)));
        dec_count = dec_count + 4'd1;
        if (b[7]) begin
          if (int'(dec_count) >= lim) dec_err = pending_error(dec_phase);
        end else begin
          v = dec_acc;
          if (lim == 5) v[63:32] = '0;
          dec_acc = '0;
          dec_count = '0;
          case (dec_phase)
            PhTag: begin
              if ((v >= 64'd1 && v <= 64'd7) || v == 64'd9) begin
                dec_tag = v[3:0];
                dec_field = '0;
                dec_phase = entry_phase(dec_tag, 3'd0);
              end else begin
                dec_err = ErrUnknownTag;
              end
            end
            PhLevel: begin
              if (v >= 64'(NumLevels)) begin
                dec_err = ErrBadLevel;
              end else begin
                add_word(KindScalar, v);
                next_field();
              end
            end
            PhNum: begin
              add_word(KindScalar, v);
              next_field();
            end
            default: begin
              add_word(KindStrLen, v);
              if (v == 64'd0) begin
                next_field();
              end else begin
                dec_left = v[31:0];
                dec_phase = PhSbytes;
              end
            end
          endcase
        end
      end
    end
    if (w.final_byte) begin
      if (dec_err == ErrNone && (dec_phase != PhTag || dec_count != 4'd0)) begin
        dec_err = pending_error(dec_phase);
      end
      done_word = '0;
      done_word.event_kind = KindEnd;
      done_word.error_code = dec_err;
      done_word.record_done = 1'b1;
      expected_words.push_back(done_word);
      clear_decoder();
    end
  endtask

  task automatic put_varint(input logic [63:0] v, input int maxlen);
    int n;
    int total;
    int i;
    n = 1;
    while (n < maxlen && (v >> (7 * n)) != 64'd0) n++;
    total = n;
    if (n < maxlen && $urandom_range(9) == 0) total = $urandom_range(maxlen, n + 1);
    for (i = 0; i < total; i++) begin
      rec.push_back({i < total - 1, 7'(v >> (7 * i))});
    end
  endtask

  task automatic put_u32(input logic [31:0] v);
    logic [63:0] x;
    x = {32'd0, v};
    if ($urandom_range(7) == 0) x[34:32] = 3'($urandom_range(7, 1));
    put_varint(x, 5);
  endtask

  function automatic logic [63:0] random_number();
    case ($urandom_range(5))
      0: return 64'($urandom_range(127));
      1: return 64'($urandom_range(1 << 20, 128));
      2: return {$urandom, $urandom};
      3: return '1;
      4: return 64'h8000_0000_0000_0000;
      default: return {32'd0, $urandom};
    endcase
  endfunction

  task automatic put_string();
    int len;
    int i;
    len = ($urandom_range(7) == 0) ? $urandom_range(20, 6) : $urandom_range(5);
    put_u32(32'(len));
    for (i = 0; i < len; i++) rec.push_back(8'($urandom));
  endtask

  task automatic put_level();
    put_u32(32'($urandom_range(NumLevels - 1)));
  endtask

  task automatic put_entry(input logic [3:0] tag);
    put_u32({28'd0, tag});
    case (tag)
      TagString: put_string();
      TagLevelStr: begin
        put_level();
        put_string();
      end
      TagLevelNum: begin
        put_level();
        put_varint(random_number(), 10);
      end
      TagLevelFull: begin
        put_level();
        put_varint(random_number(), 10);
        put_varint(random_number(), 10);
        put_string();
        put_string();
      end
      default: put_varint(random_number(), 10);
    endcase
  endtask

  task automatic put_junk();
    int i;
    int n;
    n = $urandom_range(3);
    for (i = 0; i < n; i++) rec.push_back(8'($urandom));
  endtask

  task automatic put_runon(input int n);
    int i;
    for (i = 0; i < n; i++) rec.push_back({1'b1, 7'($urandom)});
  endtask

  task automatic queue_record();
    int i;
    in_word_t w;
    for (i = 0; i < rec.size(); i++) begin
      w.data_byte = rec[i];
      w.final_byte = (i == rec.size() - 1);
      byte_queue.push_back(w);
    end
    records_queued++;
  endtask

  task automatic build_record();
    int mode;
    int n;
    int i;
    int keep;
    rec.delete();
    mode = $urandom_range(99);
    if (mode < 8) begin
      case ($urandom_range(3))
        0: put_u32(32'd0);
        1: put_u32(32'd8);
        2: put_u32(32'($urandom_range(15, 10)));
        default: put_u32($urandom);
      endcase
      put_junk();
    end else if (mode < 14) begin
      case ($urandom_range(3))
        0: put_runon(5);
        1: begin
          put_u32({28'd0, TagNumC});
          put_runon(10);
        end
        2: begin
          put_u32({28'd0, TagLevelNum});
          put_runon(5);
        end
        default: begin
          put_u32({28'd0, TagString});
          put_runon(5);
        end
      endcase
      put_junk();
    end else if (mode < 20) begin
      put_u32({28'd0, known_tags[$urandom_range(6, 4)]});
      if ($urandom_range(1) == 0) put_u32(32'($urandom_range(200, NumLevels)));
      else put_u32($urandom | 32'h8000_0000);
      put_junk();
    end else begin
      n = $urandom_range(3, 1);
      for (i = 0; i < n; i++) put_entry(known_tags[$urandom_range(7)]);
      if (mode < 30 && rec.size() > 1) begin
        keep = $urandom_range(rec.size() - 1, 1);
        while (rec.size() > keep) void'(rec.pop_back());
      end else if (mode < 36) begin
        rec[$urandom_range(rec.size() - 1)] = 8'($urandom);
      end
    end
    queue_record();
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Both sides run without idling while this window of the input stream goes by.
  function automatic logic calm();
    return bytes_sent >= 600 && bytes_sent < 900;
  endfunction

  always @(posedge clk_i) begin
    logic go;
    if (rst_ni) begin
      if (push && !full) begin
        decode_byte(item_i);
        void'(byte_queue.pop_front());
        bytes_sent++;
      end
      go = byte_queue.size() != 0 && (calm() || $urandom_range(99) >= 22);
      if (bytes_sent == 1000 && expected_words.size() != 0) go = 1'b0;
      push <= go;
      if (go) item_i <= byte_queue[0];
    end
  end

  // The receiver holds off for a long stretch once, so the queue fills and stalls the input.
  initial begin
    wait (words_checked >= 500);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (150) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          $display("%0t unexpected word: expected none, actual %0h", $time, result_o);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          compare_field("event_kind", 64'(want.event_kind), 64'(result_o.event_kind));
          compare_field("entry_tag", 64'(want.entry_tag), 64'(result_o.entry_tag));
          compare_field("field_index", 64'(want.field_index), 64'(result_o.field_index));
          compare_field("field_value", want.field_value, result_o.field_value);
          compare_field("error_code", 64'(want.error_code), 64'(result_o.error_code));
          compare_field("record_done", 64'(want.record_done), 64'(result_o.record_done));
          if (want.record_done) begin
            records_seen++;
            if (want.error_code != ErrNone) error_records++;
          end
        end
        words_checked++;
      end
      if (hold_off) begin
        pop <= 1'b0;
      end else begin
        pop <= calm() || $urandom_range(99) >= 22;
      end
    end
  end

  initial begin
    known_tags = '{TagString, TagNumA, TagNumB, TagNumC, TagLevelStr, TagLevelNum,
                   TagLevelFull, TagNumD};
    clear_decoder();

    rec = '{8'h01, 8'h01, 8'hFF};
    queue_record();
    rec = '{8'h05, 8'h06, 8'h00};
    queue_record();
    rec = '{8'h06, 8'h07};
    queue_record();
    rec = '{8'h08};
    queue_record();
    rec = '{8'h80};
    queue_record();
    rec = '{8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00};
    queue_record();
    rec = '{8'h00};
    queue_record();
    rec = '{8'h07, 8'h00, 8'h7F, 8'h00, 8'h00, 8'h01, 8'h41};
    queue_record();
    while (byte_queue.size() < 1350) build_record();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_queue.size() != 0 || expected_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d bytes in %0d records and checked %0d result words.",
             bytes_sent, records_queued, words_checked);
    $display("%0d of %0d records ended with an error status.", error_records, records_seen);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d words still expected.", expected_words.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
